/* hw/rtl/mcs_pkg.sv */
// Shared types and constants of the motion command sequencer.
// Depends on nothing; used by mcs_core and motion_command_sequencer.
package mcs_pkg;

	localparam logic [2:0] ST_IDLE      = 3'd0;
	localparam logic [2:0] ST_ACCEPTED  = 3'd1;
	localparam logic [2:0] ST_EXECUTING = 3'd2;
	localparam logic [2:0] ST_DONE      = 3'd3;
	localparam logic [2:0] ST_ABORTED   = 3'd4;
	localparam logic [2:0] ST_ERROR     = 3'd5;

	localparam logic REQ_CMD  = 1'b0;
	localparam logic REQ_TICK = 1'b1;

	localparam logic       REG_STATUS_PERIOD  = 1'b0;
	localparam logic       REG_IDLE_HEARTBEAT = 1'b1;
	localparam logic [15:0] STATUS_PERIOD_RST  = 16'd200;
	localparam logic [15:0] IDLE_HEARTBEAT_RST = 16'd1000;

	typedef struct packed {
		logic               req_type;
		logic               malformed;
		logic signed [31:0] cmd_id;
		logic signed [31:0] left_dir_raw;
		logic signed [31:0] left_pwm_raw;
		logic signed [31:0] right_dir_raw;
		logic signed [31:0] right_pwm_raw;
		logic signed [31:0] run_len;
	} item_t;

	typedef struct packed {
		logic signed [31:0] status_id;
		logic [2:0]         status_state;
		logic               status_left_dir;
		logic [7:0]         status_left_pwm;
		logic               status_right_dir;
		logic [7:0]         status_right_pwm;
		logic [30:0]        ms_left;
		logic               last_of_run;
		logic               drive_left_dir;
		logic [7:0]         drive_left_duty;
		logic               drive_right_dir;
		logic [7:0]         drive_right_duty;
	} res_t;

endpackage

/* hw/rtl/mcs_core.sv */
// Command and tick decision logic with the sequencer state registers.
// Depends on mcs_pkg. Gives up to two result beats per item.
module mcs_core
	import mcs_pkg::*;
#(
	parameter int unsigned DUTY_MAX = 255
) (
	input  logic        clk,
	input  logic        arst_n,
	input  item_t       item,
	input  logic        fire,
	input  logic [15:0] status_period,
	input  logic [15:0] idle_heartbeat,
	output logic [1:0]  n_res,
	output res_t        res0,
	output res_t        res1
);

	localparam int unsigned CapInt = (DUTY_MAX > 255) ? 255 : DUTY_MAX;
	localparam logic [7:0] DutyCap = 8'(CapInt);

	logic        busy_q, forever_q;
	logic [31:0] active_id_q;
	logic        ldir_q, rdir_q;
	logic [7:0]  lduty_q, rduty_q;
	logic [30:0] time_left_q;
	logic [15:0] since_q;

	logic        busy_d, forever_d;
	logic [31:0] active_id_d;
	logic        ldir_d, rdir_d;
	logic [7:0]  lduty_d, rduty_d;
	logic [30:0] time_left_d;
	logic [15:0] since_d;

	logic [15:0] since_inc;
	logic [30:0] tl_dec;
	logic        bad_val, stop_cmd;

	function automatic logic [7:0] clamp_duty(input logic on, input logic [7:0] duty);
		logic [7:0] r;
		r = 8'd0;
		if (on)
			r = (duty > DutyCap) ? DutyCap : duty;
		return r;
	endfunction

	function automatic res_t mk_res(
		input logic [31:0] id, input logic [2:0] st,
		input logic sld, input logic [7:0] slp, input logic srd, input logic [7:0] srp,
		input logic [30:0] rem, input logic last,
		input logic on, input logic dl, input logic [7:0] pl,
		input logic dr, input logic [7:0] pr);
		res_t r;
		r.status_id        = id;
		r.status_state     = st;
		r.status_left_dir  = sld;
		r.status_left_pwm  = slp;
		r.status_right_dir = srd;
		r.status_right_pwm = srp;
		r.ms_left          = rem;
		r.last_of_run      = last;
		r.drive_left_dir   = dl;
		r.drive_left_duty  = clamp_duty(on, pl);
		r.drive_right_dir  = dr;
		r.drive_right_duty = clamp_duty(on, pr);
		return r;
	endfunction

	assign since_inc = (since_q == 16'hFFFF) ? since_q : since_q + 16'd1;
	assign tl_dec    = (time_left_q != 31'd0) ? time_left_q - 31'd1 : time_left_q;

	assign bad_val = (item.left_dir_raw  != 32'sd0 && item.left_dir_raw  != 32'sd1)
		|| (item.right_dir_raw != 32'sd0 && item.right_dir_raw != 32'sd1)
		|| (item.left_pwm_raw[31:8]  != 24'd0)
		|| (item.right_pwm_raw[31:8] != 24'd0)
		|| item.run_len[31];
	assign stop_cmd = (item.left_pwm_raw[7:0] == 8'd0) && (item.right_pwm_raw[7:0] == 8'd0);

	always_comb begin
		busy_d      = busy_q;
		forever_d   = forever_q;
		active_id_d = active_id_q;
		ldir_d      = ldir_q;
		rdir_d      = rdir_q;
		lduty_d     = lduty_q;
		rduty_d     = rduty_q;
		time_left_d = time_left_q;
		since_d     = 16'd0;
		n_res       = 2'd1;
		res0 = mk_res(active_id_q, ST_IDLE, 1'b0, 8'd0, 1'b0, 8'd0, 31'd0, 1'b1,
			busy_q, ldir_q, lduty_q, rdir_q, rduty_q);
		res1 = res0;

		if (item.req_type == REQ_TICK) begin
			if (busy_q && !forever_q) begin
				time_left_d = tl_dec;
				if (tl_dec == 31'd0) begin
					busy_d    = 1'b0;
					forever_d = 1'b0;
					res0 = mk_res(active_id_q, ST_DONE, 1'b0, 8'd0, 1'b0, 8'd0, 31'd0,
						1'b1, 1'b0, ldir_q, lduty_q, rdir_q, rduty_q);
				end else if (since_inc >= status_period) begin
					res0 = mk_res(active_id_q, ST_EXECUTING, ldir_q, lduty_q, rdir_q,
						rduty_q, tl_dec, 1'b1, 1'b1, ldir_q, lduty_q, rdir_q, rduty_q);
				end else begin
					n_res   = 2'd0;
					since_d = since_inc;
				end
			end else if (busy_q) begin
				if (since_inc >= status_period) begin
					res0 = mk_res(active_id_q, ST_EXECUTING, ldir_q, lduty_q, rdir_q,
						rduty_q, 31'd0, 1'b1, 1'b1, ldir_q, lduty_q, rdir_q, rduty_q);
				end else begin
					n_res   = 2'd0;
					since_d = since_inc;
				end
			end else if (since_inc >= idle_heartbeat) begin
				res0 = mk_res(32'd0, ST_IDLE, 1'b0, 8'd0, 1'b0, 8'd0, 31'd0, 1'b1,
					1'b0, ldir_q, lduty_q, rdir_q, rduty_q);
			end else begin
				n_res   = 2'd0;
				since_d = since_inc;
			end
		end else if (item.malformed) begin
			res0 = mk_res(32'hFFFF_FFFF, ST_ERROR, 1'b0, 8'd0, 1'b0, 8'd0, 31'd0, 1'b1,
				busy_q, ldir_q, lduty_q, rdir_q, rduty_q);
		end else if (bad_val) begin
			res0 = mk_res(item.cmd_id, ST_ERROR, 1'b0, 8'd0, 1'b0, 8'd0, 31'd0, 1'b1,
				busy_q, ldir_q, lduty_q, rdir_q, rduty_q);
		end else if (stop_cmd) begin
			busy_d    = 1'b0;
			forever_d = 1'b0;
			// abort report for the running command goes first, both with motors off
			res1 = mk_res(item.cmd_id, ST_DONE, 1'b0, 8'd0, 1'b0, 8'd0, 31'd0, 1'b1,
				1'b0, ldir_q, lduty_q, rdir_q, rduty_q);
			if (busy_q) begin
				n_res = 2'd2;
				res0 = mk_res(active_id_q, ST_ABORTED, 1'b0, 8'd0, 1'b0, 8'd0, 31'd0,
					1'b0, 1'b0, ldir_q, lduty_q, rdir_q, rduty_q);
			end else begin
				res0 = res1;
			end
		end else if (busy_q) begin
			res0 = mk_res(item.cmd_id, ST_ERROR, 1'b0, 8'd0, 1'b0, 8'd0,
				forever_q ? 31'd0 : time_left_q, 1'b1,
				1'b1, ldir_q, lduty_q, rdir_q, rduty_q);
		end else begin
			n_res       = 2'd2;
			busy_d      = 1'b1;
			forever_d   = (item.run_len == 32'sd0);
			active_id_d = item.cmd_id;
			ldir_d      = item.left_dir_raw[0];
			rdir_d      = item.right_dir_raw[0];
			lduty_d     = item.left_pwm_raw[7:0];
			rduty_d     = item.right_pwm_raw[7:0];
			time_left_d = item.run_len[30:0];
			// accepted beat still shows the old drive levels
			res0 = mk_res(item.cmd_id, ST_ACCEPTED, item.left_dir_raw[0],
				item.left_pwm_raw[7:0], item.right_dir_raw[0], item.right_pwm_raw[7:0],
				item.run_len[30:0], 1'b0, 1'b0, ldir_q, lduty_q, rdir_q, rduty_q);
			res1 = mk_res(item.cmd_id, ST_EXECUTING, item.left_dir_raw[0],
				item.left_pwm_raw[7:0], item.right_dir_raw[0], item.right_pwm_raw[7:0],
				item.run_len[30:0], 1'b1, 1'b1, item.left_dir_raw[0],
				item.left_pwm_raw[7:0], item.right_dir_raw[0], item.right_pwm_raw[7:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			forever_q   <= 1'b0;
			active_id_q <= 32'd0;
			ldir_q      <= 1'b0;
			rdir_q      <= 1'b0;
			lduty_q     <= 8'd0;
			rduty_q     <= 8'd0;
			time_left_q <= 31'd0;
			since_q     <= 16'd0;
		end else if (fire) begin
			busy_q      <= busy_d;
			forever_q   <= forever_d;
			active_id_q <= active_id_d;
			ldir_q      <= ldir_d;
			rdir_q      <= rdir_d;
			lduty_q     <= lduty_d;
			rduty_q     <= rduty_d;
			time_left_q <= time_left_d;
			since_q     <= since_d;
		end
	end

endmodule

/* hw/rtl/motion_command_sequencer.sv */
// Motion command sequencer top level: input stage, register port, result queue.
// Depends on mcs_pkg and mcs_core.
//
//   port group    | handshake          | moves
//   --------------+--------------------+----------------------------------
//   input beat    | in_valid/in_ready  | req_type, malformed, cmd_id, raw fields
//   result beat   | out_valid/out_ready| status_*, ms_left, last_of_run, drive_*
//   registers     | APB psel/penable   | status period (0x0), idle heartbeat (0x4)
//
// An input beat is registered, then decided; its zero, one or two results are pushed
// into a two-entry result queue; a result passes the input register and the queue
// register before it is offered. One item a cycle while results drain and the queue has
// room; an item giving two results waits until both queue slots are free. Reset clears
// control and sequencer state, not item or queue data, and restores register defaults.
// A stalled output stops input only once the queue cannot take the next item's results.
module motion_command_sequencer
	import mcs_pkg::*;
#(
	parameter int unsigned DUTY_MAX = 255
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               req_type,
	input  logic               malformed,
	input  logic signed [31:0] cmd_id,
	input  logic signed [31:0] left_dir_raw,
	input  logic signed [31:0] left_pwm_raw,
	input  logic signed [31:0] right_dir_raw,
	input  logic signed [31:0] right_pwm_raw,
	input  logic signed [31:0] run_len,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] status_id,
	output logic [2:0]         status_state,
	output logic               status_left_dir,
	output logic [7:0]         status_left_pwm,
	output logic               status_right_dir,
	output logic [7:0]         status_right_pwm,
	output logic [30:0]        ms_left,
	output logic               last_of_run,
	output logic               drive_left_dir,
	output logic [7:0]         drive_left_duty,
	output logic               drive_right_dir,
	output logic [7:0]         drive_right_duty
);

	logic [15:0] period_q, heartbeat_q;
	logic        cfg_wr;

	item_t       item_s1;
	logic        valid_s1;
	logic        fire;
	logic [1:0]  n_res;
	res_t        res0, res1;

	res_t        queue_q [2];
	logic        wr_ptr_q, rd_ptr_q;
	logic [1:0]  count_q;
	logic        pop;
	logic [1:0]  free;
	res_t        head;

	// register port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign prdata = {16'd0, (paddr[2] == REG_IDLE_HEARTBEAT) ? heartbeat_q : period_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q    <= STATUS_PERIOD_RST;
			heartbeat_q <= IDLE_HEARTBEAT_RST;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_STATUS_PERIOD:  period_q    <= pwdata[15:0];
				REG_IDLE_HEARTBEAT: heartbeat_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// input stage
	assign pop      = out_valid && out_ready;
	assign free     = 2'd2 - count_q + {1'b0, pop};
	assign fire     = valid_s1 && (n_res <= free);
	assign in_ready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_ready)
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1.req_type      <= req_type;
			item_s1.malformed     <= malformed;
			item_s1.cmd_id        <= cmd_id;
			item_s1.left_dir_raw  <= left_dir_raw;
			item_s1.left_pwm_raw  <= left_pwm_raw;
			item_s1.right_dir_raw <= right_dir_raw;
			item_s1.right_pwm_raw <= right_pwm_raw;
			item_s1.run_len       <= run_len;
		end
	end

	mcs_core #(
		.DUTY_MAX(DUTY_MAX)
	) u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.item          (item_s1),
		.fire          (fire),
		.status_period (period_q),
		.idle_heartbeat(heartbeat_q),
		.n_res         (n_res),
		.res0          (res0),
		.res1          (res1)
	);

	// result queue, two entries
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (fire)
				wr_ptr_q <= wr_ptr_q ^ n_res[0];
			if (pop)
				rd_ptr_q <= ~rd_ptr_q;
			count_q <= count_q + (fire ? n_res : 2'd0) - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (fire && n_res != 2'd0)
			queue_q[wr_ptr_q] <= res0;
		if (fire && n_res == 2'd2)
			queue_q[~wr_ptr_q] <= res1;
	end

	assign out_valid = (count_q != 2'd0);
	assign head      = queue_q[rd_ptr_q];

	assign status_id        = head.status_id;
	assign status_state     = head.status_state;
	assign status_left_dir  = head.status_left_dir;
	assign status_left_pwm  = head.status_left_pwm;
	assign status_right_dir = head.status_right_dir;
	assign status_right_pwm = head.status_right_pwm;
	assign ms_left          = head.ms_left;
	assign last_of_run      = head.last_of_run;
	assign drive_left_dir   = head.drive_left_dir;
	assign drive_left_duty  = head.drive_left_duty;
	assign drive_right_dir  = head.drive_right_dir;
	assign drive_right_duty = head.drive_right_duty;

endmodule

/* bench/motion_command_sequencer_tb.sv */
`timescale 1ns / 1ps
// Self-checking bench for motion_command_sequencer: command and tick beats in,
// status beats out, checked against a status scoreboard kept alongside.
// Depends on mcs_pkg and the motion_command_sequencer RTL.

class status_scoreboard;
	mcs_pkg::res_t due_status[$];
	int unsigned mismatches;
	int unsigned duty_cap;
	bit [15:0] status_period;
	bit [15:0] heartbeat_period;
	// sequencer state; all of it is zero out of reset
	bit busy;
	bit runs_forever;
	bit [31:0] active_id;
	bit held_left_dir;
	bit held_right_dir;
	bit [7:0] held_left_duty;
	bit [7:0] held_right_duty;
	bit [30:0] time_left;
	bit [15:0] since_publish;

	function new(int unsigned cap);
		duty_cap = cap;
		status_period = mcs_pkg::STATUS_PERIOD_RST;
		heartbeat_period = mcs_pkg::IDLE_HEARTBEAT_RST;
	endfunction

	function void set_register(bit idx, bit [15:0] value);
		if (idx == mcs_pkg::REG_STATUS_PERIOD) begin
			status_period = value;
		end else begin
			heartbeat_period = value;
		end
	endfunction

	function bit [7:0] drive_level(bit [7:0] duty);
		if (!busy)
			return 8'd0;
		return (duty > duty_cap) ? duty_cap[7:0] : duty;
	endfunction

	function bit [30:0] time_to_go();
		return (busy && !runs_forever) ? time_left : 31'd0;
	endfunction

	// drive fields reflect the state at the moment the report goes out
	function void push_status(bit [31:0] id, bit [2:0] st, bit ld, bit [7:0] lp, bit rd,
			bit [7:0] rp, bit [30:0] rem, bit last);
		mcs_pkg::res_t r;
		r.status_id = id;
		r.status_state = st;
		r.status_left_dir = ld;
		r.status_left_pwm = lp;
		r.status_right_dir = rd;
		r.status_right_pwm = rp;
		r.ms_left = rem;
		r.last_of_run = last;
		r.drive_left_dir = held_left_dir;
		r.drive_left_duty = drive_level(held_left_duty);
		r.drive_right_dir = held_right_dir;
		r.drive_right_duty = drive_level(held_right_duty);
		due_status.push_back(r);
		since_publish = '0;
	endfunction

	function void take_request(mcs_pkg::item_t it);
		bit [31:0] id;
		int ld;
		int lp;
		int rd;
		int rp;
		int dur;
		if (it.req_type == mcs_pkg::REQ_TICK) begin
			if (since_publish != 16'hFFFF)
				since_publish++;
			if (busy && !runs_forever) begin
				if (time_left != 0)
					time_left--;
				if (time_left == 0) begin
					busy = 1'b0;
					push_status(active_id, mcs_pkg::ST_DONE, 0, 0, 0, 0, 0, 1);
				end else if (since_publish >= status_period) begin
					push_status(active_id, mcs_pkg::ST_EXECUTING, held_left_dir,
						held_left_duty, held_right_dir, held_right_duty, time_left, 1);
				end
			end else if (busy) begin
				if (since_publish >= status_period)
					push_status(active_id, mcs_pkg::ST_EXECUTING, held_left_dir,
						held_left_duty, held_right_dir, held_right_duty, 0, 1);
			end else if (since_publish >= heartbeat_period) begin
				push_status(0, mcs_pkg::ST_IDLE, 0, 0, 0, 0, 0, 1);
			end
			return;
		end
		if (it.malformed) begin
			push_status(32'hFFFF_FFFF, mcs_pkg::ST_ERROR, 0, 0, 0, 0, 0, 1);
			return;
		end
		id = it.cmd_id;
		ld = it.left_dir_raw;
		lp = it.left_pwm_raw;
		rd = it.right_dir_raw;
		rp = it.right_pwm_raw;
		dur = it.run_len;
		if ((ld != 0 && ld != 1) || (rd != 0 && rd != 1) || lp < 0 || lp > 255 ||
				rp < 0 || rp > 255 || dur < 0) begin
			push_status(id, mcs_pkg::ST_ERROR, 0, 0, 0, 0, 0, 1);
			return;
		end
		// both duties zero: stop, aborting whatever runs
		if (lp == 0 && rp == 0) begin
			runs_forever = 1'b0;
			if (busy) begin
				busy = 1'b0;
				push_status(active_id, mcs_pkg::ST_ABORTED, 0, 0, 0, 0, 0, 0);
			end
			push_status(id, mcs_pkg::ST_DONE, 0, 0, 0, 0, 0, 1);
			return;
		end
		if (busy) begin
			push_status(id, mcs_pkg::ST_ERROR, 0, 0, 0, 0, time_to_go(), 1);
			return;
		end
		// accepted report still carries the old drive levels
		push_status(id, mcs_pkg::ST_ACCEPTED, ld[0], lp[7:0], rd[0], rp[7:0], dur[30:0], 0);
		active_id = id;
		held_left_dir = ld[0];
		held_left_duty = lp[7:0];
		held_right_dir = rd[0];
		held_right_duty = rp[7:0];
		time_left = dur[30:0];
		runs_forever = (dur == 0);
		busy = 1'b1;
		push_status(id, mcs_pkg::ST_EXECUTING, held_left_dir, held_left_duty,
			held_right_dir, held_right_duty, time_to_go(), 1);
	endfunction

	task report_mismatch(string what);
		mismatches++;
		$display("%0t mismatch: %s", $realtime, what);
	endtask

	task compare_field(string name, logic [31:0] got, logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got 0x%0h, want 0x%0h", name, got, want));
	endtask

	task check_status(mcs_pkg::res_t got);
		mcs_pkg::res_t want;
		if (due_status.size() == 0) begin
			report_mismatch($sformatf("unexpected status beat, id 0x%0h state %0d",
				got.status_id, got.status_state));
			return;
		end
		want = due_status.pop_front();
		compare_field("status_id", got.status_id, want.status_id);
		compare_field("status_state", got.status_state, want.status_state);
		compare_field("status_left_dir", got.status_left_dir, want.status_left_dir);
		compare_field("status_left_pwm", got.status_left_pwm, want.status_left_pwm);
		compare_field("status_right_dir", got.status_right_dir, want.status_right_dir);
		compare_field("status_right_pwm", got.status_right_pwm, want.status_right_pwm);
		compare_field("ms_left", got.ms_left, want.ms_left);
		compare_field("last_of_run", got.last_of_run, want.last_of_run);
		compare_field("drive_left_dir", got.drive_left_dir, want.drive_left_dir);
		compare_field("drive_left_duty", got.drive_left_duty, want.drive_left_duty);
		compare_field("drive_right_dir", got.drive_right_dir, want.drive_right_dir);
		compare_field("drive_right_duty", got.drive_right_duty, want.drive_right_duty);
	endtask
endclass

module motion_command_sequencer_tb;
	import mcs_pkg::*;

	localparam int unsigned DUTY_MAX = 255;
	localparam int unsigned SETTLE_CYCLES = 16;
	localparam longint unsigned CYCLE_LIMIT = 1_000_000;

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [2:0]         paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;
	logic               in_valid;
	logic               in_ready;
	logic               req_type;
	logic               malformed;
	logic signed [31:0] cmd_id;
	logic signed [31:0] left_dir_raw;
	logic signed [31:0] left_pwm_raw;
	logic signed [31:0] right_dir_raw;
	logic signed [31:0] right_pwm_raw;
	logic signed [31:0] run_len;
	logic               out_valid;
	logic               out_ready;
	logic signed [31:0] status_id;
	logic [2:0]         status_state;
	logic               status_left_dir;
	logic [7:0]         status_left_pwm;
	logic               status_right_dir;
	logic [7:0]         status_right_pwm;
	logic [30:0]        ms_left;
	logic               last_of_run;
	logic               drive_left_dir;
	logic [7:0]         drive_left_duty;
	logic               drive_right_dir;
	logic [7:0]         drive_right_duty;

	int unsigned send_idle_pct;
	int unsigned recv_stall_pct;
	longint unsigned cycle_count = 0;
	status_scoreboard board;

	motion_command_sequencer #(.DUTY_MAX(DUTY_MAX)) i_dut (.*);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("motion_command_sequencer_tb: done, errors");
			$finish;
		end
	end

	// result side: check each accepted beat, then pick the next ready level
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				board.check_status({status_id, status_state, status_left_dir,
					status_left_pwm, status_right_dir, status_right_pwm, ms_left,
					last_of_run, drive_left_dir, drive_left_duty, drive_right_dir,
					drive_right_duty});
			out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	function automatic item_t make_command(int id, int ld, int lp, int rd, int rp, int dur);
		item_t it;
		it.req_type = REQ_CMD;
		it.malformed = 1'b0;
		it.cmd_id = id;
		it.left_dir_raw = ld;
		it.left_pwm_raw = lp;
		it.right_dir_raw = rd;
		it.right_pwm_raw = rp;
		it.run_len = dur;
		return it;
	endfunction

	// the block ignores everything but req_type on a tick, so fill it with noise
	function automatic item_t make_tick();
		item_t it;
		it.req_type = REQ_TICK;
		it.malformed = $urandom_range(0, 1);
		it.cmd_id = $urandom;
		it.left_dir_raw = $urandom;
		it.left_pwm_raw = $urandom;
		it.right_dir_raw = $urandom;
		it.right_pwm_raw = $urandom;
		it.run_len = $urandom;
		return it;
	endfunction

	function automatic item_t random_item();
		item_t it;
		int pick;
		int span;
		int dur;
		pick = $urandom_range(0, 99);
		if (pick < 55)
			return make_tick();
		span = $urandom_range(0, 9);
		if (span == 0)
			dur = 0;
		else if (span == 1)
			dur = $urandom & 32'h7FFF_FFFF;
		else
			dur = $urandom_range(1, 24);
		it = make_command($urandom, $urandom_range(0, 1), $urandom_range(0, 255),
			$urandom_range(0, 1), $urandom_range(0, 255), dur);
		if (pick < 63) begin
			it.left_pwm_raw = 0;
			it.right_pwm_raw = 0;
		end else if (pick < 68) begin
			it = make_tick();
			it.req_type = REQ_CMD;
			it.malformed = 1'b1;
		end else if (pick < 78) begin
			case ($urandom_range(0, 4))
				0: it.left_dir_raw = $urandom;
				1: it.right_dir_raw = $urandom;
				2: it.left_pwm_raw = $urandom;
				3: it.right_pwm_raw = $urandom;
				default: it.run_len = $urandom | 32'h8000_0000;
			endcase
		end
		return it;
	endfunction

	task automatic send_item(input item_t it);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= it.req_type;
		malformed <= it.malformed;
		cmd_id <= it.cmd_id;
		left_dir_raw <= it.left_dir_raw;
		left_pwm_raw <= it.left_pwm_raw;
		right_dir_raw <= it.right_dir_raw;
		right_pwm_raw <= it.right_pwm_raw;
		run_len <= it.run_len;
		do
			@(posedge clk);
		while (!in_ready);
		board.take_request(it);
	endtask

	// drop valid, drain every due report, then allow for ticks still in flight
	task automatic settle();
		in_valid <= 1'b0;
		while (board.due_status.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic program_reg(input logic idx, input logic [15:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {16'h0000, value};
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		board.set_register(idx, value);
		// straight into the read-back setup
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		if (prdata[15:0] !== value)
			board.report_mismatch($sformatf("register %0d reads 0x%0h, want 0x%0h",
				idx, prdata[15:0], value));
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic run_phase(input logic [15:0] period, input logic [15:0] heartbeat,
			input int unsigned idle_pct, input int unsigned stall_pct, input int unsigned count);
		settle();
		program_reg(REG_STATUS_PERIOD, period);
		program_reg(REG_IDLE_HEARTBEAT, heartbeat);
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		repeat (count) send_item(random_item());
	endtask

	initial begin
		item_t short_msg;
		board = new(DUTY_MAX);
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		req_type = REQ_CMD;
		malformed = 1'b0;
		cmd_id = '0;
		left_dir_raw = '0;
		left_pwm_raw = '0;
		right_dir_raw = '0;
		right_pwm_raw = '0;
		run_len = '0;
		out_ready = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: every error path, stop idle and busy, timed and endless runs
		run_phase(16'd2, 16'd5, 0, 0, 0);
		short_msg = make_command(11, 0, 100, 1, 100, 5);
		short_msg.malformed = 1'b1;
		send_item(short_msg);
		send_item(make_command(12, 2, 10, 0, 10, 5));
		send_item(make_command(13, 0, 10, -1, 10, 5));
		send_item(make_command(14, 1, 256, 1, 10, 5));
		send_item(make_command(15, 1, 10, 1, -1, 5));
		send_item(make_command(16, 1, 10, 1, 10, 32'sh8000_0000));
		send_item(make_command(17, 0, 0, 1, 0, 9));
		send_item(make_command(18, 1, 255, 0, 1, 3));
		send_item(make_command(19, 0, 5, 0, 5, 9));
		repeat (3) send_item(make_tick());
		send_item(make_command(32'sh7FFF_FFFF, 1, 0, 1, 200, 0));
		repeat (3) send_item(make_tick());
		send_item(make_command(21, 1, 1, 1, 1, 100));
		send_item(make_command(22, 1, 0, 0, 0, 0));
		repeat (5) send_item(make_tick());
		send_item(make_command(32'sh8000_0000, 1, 128, 1, 127, 32'sh7FFF_FFFF));
		send_item(make_command(0, 0, 0, 0, 0, 32'sh7FFF_FFFF));

		run_phase(16'd1, 16'd1, 0, 0, 120);
		run_phase(16'd7, 16'd13, 69, 0, 120);
		run_phase(16'd3, 16'hFFFF, 0, 69, 120);
		run_phase(16'hFFFF, 16'd4, 36, 36, 120);
		run_phase(16'd5, 16'd9, 0, 0, 20);
		settle();

		if (board.mismatches == 0)
			$display("motion_command_sequencer_tb: done, clean");
		else
			$display("motion_command_sequencer_tb: done, errors");
		$finish;
	end
endmodule

/* motion_command_sequencer.f */
hw/rtl/mcs_pkg.sv
hw/rtl/mcs_core.sv
hw/rtl/motion_command_sequencer.sv
bench/motion_command_sequencer_tb.sv
